// ----- rtl/qacw_pkg.sv -----
// ----------------------------------------------------------------------------
// qacw_pkg
// Shared types and constants for the wrapping quadrature angle counter.
// ----------------------------------------------------------------------------
package qacw_pkg;

	localparam int POS_WIDTH_DEF = 16;
	localparam int UPPER_RESET   = 719;
	localparam int LOWER_RESET   = -719;

	// Configuration register index; two codes spare so stray writes are dropped
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_UPPER_LIMIT = 2'd0,
		REG_LOWER_LIMIT = 2'd1
	} cfg_reg_t;

	typedef enum logic {
		ACT_SAMPLE = 1'b0,
		ACT_LOAD   = 1'b1
	} action_t;

	typedef enum logic {
		DIR_CW  = 1'b0,
		DIR_CCW = 1'b1
	} dir_t;

	// Control part of the registered input item
	typedef struct packed {
		logic valid;
		logic action;
		logic chan_a;
		logic chan_b;
	} smp_ctl_t;

endpackage

// ----- rtl/qacw_ifs.sv -----
// ----------------------------------------------------------------------------
// qacw interfaces
// Sample, result and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface qacw_sample_if #(
	parameter int W = 16
);
	logic                valid;
	logic                ready;
	logic                action;
	logic                chan_a;
	logic                chan_b;
	logic signed [W-1:0] load_value;

	modport source (output valid, action, chan_a, chan_b, load_value, input ready);
	modport sink   (input valid, action, chan_a, chan_b, load_value, output ready);
endinterface

interface qacw_result_if #(
	parameter int W = 16
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] position;
	logic                turn_dir;
	logic                moved;
	logic                bad_step;

	modport source (output valid, position, turn_dir, moved, bad_step, input ready);
	modport sink   (input valid, position, turn_dir, moved, bad_step, output ready);
endinterface

interface qacw_cfg_if #(
	parameter int W     = 16,
	parameter int IDX_W = 2
);
	logic                valid;
	logic                ready;
	logic [IDX_W-1:0]    index;
	logic signed [W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/qacw_cfg.sv -----
// ----------------------------------------------------------------------------
// qacw_cfg
// Limit registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module qacw_cfg #(
	parameter int W = qacw_pkg::POS_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	qacw_cfg_if.sink            cfg,
	output logic signed [W-1:0] upper_limit,
	output logic signed [W-1:0] lower_limit
);
	import qacw_pkg::*;

	localparam logic signed [W-1:0] UP_RST = W'(UPPER_RESET);
	localparam logic signed [W-1:0] LO_RST = W'(LOWER_RESET);

	logic signed [W-1:0] upper_q;
	logic signed [W-1:0] lower_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upper_q <= UP_RST;
			lower_q <= LO_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_UPPER_LIMIT: upper_q <= cfg.data;
				REG_LOWER_LIMIT: lower_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign upper_limit = upper_q;
	assign lower_limit = lower_q;

endmodule

// ----- rtl/qacw_in_reg.sv -----
// ----------------------------------------------------------------------------
// qacw_in_reg
// Input register stage for sample/load items.
// ----------------------------------------------------------------------------
module qacw_in_reg #(
	parameter int W = qacw_pkg::POS_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	qacw_sample_if.sink          samples,
	input  logic                 adv,
	output qacw_pkg::smp_ctl_t   ctl_s1,
	output logic signed [W-1:0]  load_value_s1
);
	import qacw_pkg::*;

	smp_ctl_t ctl_q;
	logic     take;

	// stage frees up when its item moves on this cycle
	assign samples.ready = !ctl_q.valid || adv;
	assign take          = samples.valid && samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (take) begin
			ctl_q.valid  <= 1'b1;
			ctl_q.action <= samples.action;
			ctl_q.chan_a <= samples.chan_a;
			ctl_q.chan_b <= samples.chan_b;
		end else if (adv) begin
			ctl_q.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			load_value_s1 <= samples.load_value;
		end
	end

	assign ctl_s1 = ctl_q;

endmodule

// ----- rtl/qacw_step.sv -----
// ----------------------------------------------------------------------------
// qacw_step
// Edge decode, counter state with wrap, and result register.
// ----------------------------------------------------------------------------
module qacw_step #(
	parameter int W = qacw_pkg::POS_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  qacw_pkg::smp_ctl_t  ctl_s1,
	input  logic signed [W-1:0] load_value_s1,
	input  logic signed [W-1:0] upper_limit,
	input  logic signed [W-1:0] lower_limit,
	output logic                adv,
	qacw_result_if.source       results
);
	import qacw_pkg::*;

	localparam logic signed [W-1:0] CNT_RST = W'(LOWER_RESET);

	logic                last_a_q;
	logic                last_b_q;
	logic signed [W-1:0] count_q;
	logic                dir_q;

	logic                res_valid_q;
	logic signed [W-1:0] res_pos_q;
	logic                res_dir_q;
	logic                res_moved_q;
	logic                res_bad_q;

	logic                proc;
	logic                ch_a;
	logic                ch_b;
	logic                step;
	logic                bad;
	logic                dir_nx;
	logic signed [W:0]   sum;
	logic signed [W:0]   wrap_hi;
	logic signed [W-1:0] count_nx;
	logic                is_load;

	assign adv     = !res_valid_q || results.ready;
	assign proc    = ctl_s1.valid && adv;
	assign is_load = (ctl_s1.action == ACT_LOAD);

	assign ch_a = ctl_s1.chan_a != last_a_q;
	assign ch_b = ctl_s1.chan_b != last_b_q;
	assign bad  = !is_load && ch_a && ch_b;
	assign step = !is_load && (ch_a ^ ch_b);

	always_comb begin
		dir_nx = dir_q;
		if (step) begin
			if (ch_a) begin
				dir_nx = (ctl_s1.chan_a == ctl_s1.chan_b) ? DIR_CCW : DIR_CW;
			end else begin
				dir_nx = (ctl_s1.chan_a != ctl_s1.chan_b) ? DIR_CCW : DIR_CW;
			end
		end
	end

	// one guard bit so a step past the range edge still compares correctly
	always_comb begin
		sum     = (dir_nx == DIR_CCW) ? ({count_q[W-1], count_q} + (W+1)'(1))
		                              : ({count_q[W-1], count_q} - (W+1)'(1));
		wrap_hi = (sum > $signed({upper_limit[W-1], upper_limit}))
		        ? $signed({lower_limit[W-1], lower_limit}) : sum;
		if (is_load) begin
			count_nx = load_value_s1;
		end else if (step) begin
			count_nx = (wrap_hi < $signed({lower_limit[W-1], lower_limit})) ? upper_limit
			                                                                  : wrap_hi[W-1:0];
		end else begin
			count_nx = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_a_q <= 1'b0;
			last_b_q <= 1'b0;
			count_q  <= CNT_RST;
			dir_q    <= DIR_CW;
		end else if (proc) begin
			count_q <= count_nx;
			dir_q   <= dir_nx;
			if (!is_load) begin
				last_a_q <= ctl_s1.chan_a;
				last_b_q <= ctl_s1.chan_b;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= ctl_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			res_pos_q   <= count_nx;
			res_dir_q   <= dir_nx;
			res_moved_q <= step;
			res_bad_q   <= bad;
		end
	end

	assign results.valid    = res_valid_q;
	assign results.position = res_pos_q;
	assign results.turn_dir = res_dir_q;
	assign results.moved    = res_moved_q;
	assign results.bad_step = res_bad_q;

endmodule

// ----- rtl/quadrature_angle_counter_wrap_top.sv -----
// ----------------------------------------------------------------------------
// quadrature_angle_counter_wrap_top
// Four-times quadrature decoder with a wrapping angle position counter.
// ----------------------------------------------------------------------------
// Each transfer on the sample channel yields exactly one transfer on the
// result channel. The block takes one item per clock cycle while the result
// channel accepts: the item lands in an input register, and the edge decode
// plus the counter update (one add and two limit compares) run from there
// into the result register, and the counter state is updated along with it,
// so the next item sees it without any bubble. A single-channel change
// steps the count by one (CCW up, CW down); past upper_limit the count goes to
// lower_limit, below lower_limit to upper_limit. A change on both channels
// holds the count and raises bad_step. A load item overwrites the position and
// leaves the stored channel levels alone. Limits are written through the cfg
// channel (index 0 upper, 1 lower; other indexes are ignored); cfg is always
// ready and should only be used while no item is in flight.
// ----------------------------------------------------------------------------
module quadrature_angle_counter_wrap_top #(
	parameter int POS_WIDTH = qacw_pkg::POS_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	qacw_sample_if.sink    samples,
	qacw_result_if.source  results,
	qacw_cfg_if.sink       cfg
);
	import qacw_pkg::*;

	smp_ctl_t                    ctl_s1;
	logic signed [POS_WIDTH-1:0] load_value_s1;
	logic signed [POS_WIDTH-1:0] upper_limit;
	logic signed [POS_WIDTH-1:0] lower_limit;
	logic                        adv;

	// limit registers
	qacw_cfg #(.W(POS_WIDTH)) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.upper_limit (upper_limit),
		.lower_limit (lower_limit)
	);

	// input register; frees up whenever the result side can move
	qacw_in_reg #(.W(POS_WIDTH)) u_in_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.samples       (samples),
		.adv           (adv),
		.ctl_s1        (ctl_s1),
		.load_value_s1 (load_value_s1)
	);

	// decode, counter state and result register
	qacw_step #(.W(POS_WIDTH)) u_step (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl_s1        (ctl_s1),
		.load_value_s1 (load_value_s1),
		.upper_limit   (upper_limit),
		.lower_limit   (lower_limit),
		.adv           (adv),
		.results       (results)
	);

endmodule
